/* sv/rsnc_pkg.sv */
// shared types, constants and helpers for the ray cell-boundary step
package rsnc_pkg;

  localparam int CoordW = 32;                 // q16.16 coordinate width
  localparam int GapW   = 17;                 // gap magnitude, 1 to 65536 lsb
  localparam int FaceW  = 34;                 // face in offset form, signed
  localparam int DvdW   = 52;                 // dividend width, gap << 32 padded
  localparam int Bps    = 4;                  // quotient bits per divider stage
  localparam int NDiv   = DvdW / Bps;         // divider stages
  localparam int TW     = DvdW;               // ray parameter width
  localparam int SumW   = 35;                 // signed offset sum width
  localparam int AdvW   = 33;                 // clipped advance width

  localparam logic [TW-1:0]     TInf     = {TW{1'b1}};
  localparam logic [CoordW-1:0] SignBias = 32'h8000_0000;
  localparam logic [AdvW-1:0]   AdvMax   = {AdvW{1'b1}};

  typedef struct packed {
    logic [CoordW-1:0]       u;      // start in offset binary
    logic signed [FaceW-1:0] face;   // target face in offset binary
    logic [CoordW-1:0]       mag;    // |heading|
    logic                    neg;    // heading negative
  } axis_t;

  typedef struct packed {
    logic [CoordW-1:0] rem;
    logic [DvdW-1:0]   quot;
    logic [DvdW-1:0]   dvd;
  } div_t;

  // clamp an offset value to the int32 range and return two's complement bits
  function automatic logic [CoordW-1:0] sat_off(input logic signed [SumW-1:0] off);
    logic [CoordW-1:0] r;
    if (off < 0) begin
      r = '0;
    end else if (off > $signed({3'b000, {CoordW{1'b1}}})) begin
      r = '1;
    end else begin
      r = off[CoordW-1:0];
    end
    return r ^ SignBias;
  endfunction

endpackage

/* sv/ray_step_to_next_cell_boundary_core.sv */
// top level: pipelined ray step to the next unit-cell face
// A request carries a ray start and heading in signed q16.16 and yields one
// result, the point where the ray first meets a unit-cell face, saturated to
// the int32 range. A new request is taken every cycle while in_stall is low.
// There are 17 register stages: face selection, 13 divider stages that each
// resolve 4 quotient bits of the radix-2 restoring division, the minimum
// search, the multiply and the final sum. Every stage holds its own valid bit
// and stalls only when the stage after it is full and stalled, so bubbles are
// squeezed out and requests still enter while a result waits.
module ray_step_to_next_cell_boundary_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] start_z,
  input  logic [31:0] heading_x,
  input  logic [31:0] heading_y,
  input  logic [31:0] heading_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_x,
  output logic [31:0] next_y,
  output logic [31:0] next_z
);

  // stage map: prep, divider stages, minimum, multiply, output
  localparam int SMin = rsnc_pkg::NDiv + 1;
  localparam int SMul = SMin + 1;
  localparam int SOut = SMul + 1;
  localparam int NSt  = SOut + 1;

  logic [NSt-1:0] vld;
  logic [NSt-1:0] en;

  rsnc_pkg::axis_t ax [0:rsnc_pkg::NDiv][0:2];
  rsnc_pkg::div_t  dv [0:rsnc_pkg::NDiv][0:2];

  logic [31:0] starts   [0:2];
  logic [31:0] headings [0:2];
  logic [31:0] coords   [0:2];

  logic [rsnc_pkg::TW-1:0] t [0:2];
  logic [rsnc_pkg::TW-1:0] tmin_next;
  logic [rsnc_pkg::TW-1:0] tmin;
  logic [2:0]              snap;
  rsnc_pkg::axis_t         ax_min [0:2];

  assign starts[0]   = start_x;
  assign starts[1]   = start_y;
  assign starts[2]   = start_z;
  assign headings[0] = heading_x;
  assign headings[1] = heading_y;
  assign headings[2] = heading_z;

  // a stage may load when it is empty or the next one moves on
  always_comb begin
    en[NSt-1] = !vld[NSt-1] || !out_stall;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSt-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  genvar a, s;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      rsnc_prep u_prep (
        .clk     (clk),
        .en      (en[0]),
        .start   (starts[a]),
        .heading (headings[a]),
        .ax      (ax[0][a]),
        .dv      (dv[0][a])
      );
      for (s = 1; s <= rsnc_pkg::NDiv; s++) begin : g_div
        rsnc_div_stage u_div (
          .clk   (clk),
          .en    (en[s]),
          .ax_in (ax[s-1][a]),
          .dv_in (dv[s-1][a]),
          .ax    (ax[s][a]),
          .dv    (dv[s][a])
        );
      end
      // zero heading stands for an infinite ray parameter
      assign t[a] = (ax[rsnc_pkg::NDiv][a].mag == '0) ? rsnc_pkg::TInf
                                                      : dv[rsnc_pkg::NDiv][a].quot;
      rsnc_advance u_adv (
        .clk     (clk),
        .en_mul  (en[SMul]),
        .en_out  (en[SOut]),
        .ax_in   (ax_min[a]),
        .snap_in (snap[a]),
        .tmin    (tmin),
        .coord   (coords[a])
      );
    end
  endgenerate

  // smallest parameter across the three axes
  always_comb begin
    tmin_next = t[0];
    if (t[1] < tmin_next) begin
      tmin_next = t[1];
    end
    if (t[2] < tmin_next) begin
      tmin_next = t[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[SMin]) begin
      tmin <= tmin_next;
      for (int i = 0; i < 3; i++) begin
        snap[i]   <= (t[i] == tmin_next);
        ax_min[i] <= ax[rsnc_pkg::NDiv][i];
      end
    end
  end

  assign next_x = coords[0];
  assign next_y = coords[1];
  assign next_z = coords[2];

endmodule

/* sv/rsnc_prep.sv */
// per-axis face selection and gap, registered
module rsnc_prep (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rsnc_pkg::CoordW-1:0]   start,
  input  logic [rsnc_pkg::CoordW-1:0]   heading,
  output rsnc_pkg::axis_t               ax,
  output rsnc_pkg::div_t                dv
);

  rsnc_pkg::axis_t                ax_next;
  logic [rsnc_pkg::GapW-1:0]      gap;
  logic                           pos;
  logic signed [rsnc_pkg::FaceW-1:0] fl;
  logic [15:0]                    frac;

  always_comb begin
    ax_next.u   = start ^ rsnc_pkg::SignBias;
    ax_next.neg = heading[rsnc_pkg::CoordW-1];
    ax_next.mag = ax_next.neg ? (~heading + 32'd1) : heading;
    pos  = (heading != '0) && !ax_next.neg;
    frac = ax_next.u[15:0];
    fl   = $signed({2'b00, ax_next.u[31:16], 16'h0000});
    if (pos) begin
      ax_next.face = fl + 34'sd65536;
      gap = (frac == 16'h0) ? 17'h10000 : (17'h10000 - {1'b0, frac});
    end else if (frac != 16'h0) begin
      ax_next.face = fl;
      gap = {1'b0, frac};
    end else begin
      ax_next.face = fl - 34'sd65536;
      gap = 17'h10000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax      <= ax_next;
      dv.rem  <= '0;
      dv.quot <= '0;
      dv.dvd  <= {{(rsnc_pkg::DvdW-rsnc_pkg::GapW-32){1'b0}}, gap, 32'h0};
    end
  end

endmodule

/* sv/rsnc_div_stage.sv */
// one stage of the restoring divider, 4 quotient bits per stage
module rsnc_div_stage (
  input  logic            clk,
  input  logic            en,
  input  rsnc_pkg::axis_t ax_in,
  input  rsnc_pkg::div_t  dv_in,
  output rsnc_pkg::axis_t ax,
  output rsnc_pkg::div_t  dv
);

  rsnc_pkg::div_t dv_next;
  logic [rsnc_pkg::CoordW:0] r;

  always_comb begin
    dv_next = dv_in;
    r = '0;
    for (int b = 0; b < rsnc_pkg::Bps; b++) begin
      r = {dv_next.rem, dv_next.dvd[rsnc_pkg::DvdW-1]};
      dv_next.dvd = {dv_next.dvd[rsnc_pkg::DvdW-2:0], 1'b0};
      if (r >= {1'b0, ax_in.mag}) begin
        r = r - {1'b0, ax_in.mag};
        dv_next.quot = {dv_next.quot[rsnc_pkg::DvdW-2:0], 1'b1};
      end else begin
        dv_next.quot = {dv_next.quot[rsnc_pkg::DvdW-2:0], 1'b0};
      end
      dv_next.rem = r[rsnc_pkg::CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= ax_in;
      dv <= dv_next;
    end
  end

endmodule

/* sv/rsnc_advance.sv */
// advance by heading times t, or snap to the face; two register stages
module rsnc_advance (
  input  logic                         clk,
  input  logic                         en_mul,
  input  logic                         en_out,
  input  rsnc_pkg::axis_t              ax_in,
  input  logic                         snap_in,
  input  logic [rsnc_pkg::TW-1:0]      tmin,
  output logic [rsnc_pkg::CoordW-1:0]  coord
);

  rsnc_pkg::axis_t ax;
  logic            snap;
  logic [63:0]     p_lo;
  logic [48:0]     p_hi;
  logic [49:0]     adv_full;
  logic [rsnc_pkg::AdvW-1:0] adv;
  logic signed [rsnc_pkg::SumW-1:0] sadv;
  logic signed [rsnc_pkg::SumW-1:0] sum;
  logic [rsnc_pkg::CoordW-1:0] coord_next;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      ax   <= ax_in;
      snap <= snap_in;
      p_lo <= {32'h0, ax_in.mag} * {32'h0, tmin[31:0]};
      p_hi <= {17'h0, ax_in.mag} * {32'h0, tmin[48:32]};
    end
  end

  always_comb begin
    adv_full = {1'b0, p_hi} + {18'h0, p_lo[63:32]};
    adv  = (adv_full > {17'h0, rsnc_pkg::AdvMax}) ? rsnc_pkg::AdvMax
                                                 : adv_full[rsnc_pkg::AdvW-1:0];
    sadv = ax.neg ? -$signed({2'b00, adv}) : $signed({2'b00, adv});
    sum  = $signed({3'b000, ax.u}) + sadv;
    if (snap) begin
      coord_next = rsnc_pkg::sat_off({ax.face[rsnc_pkg::FaceW-1], ax.face});
    end else begin
      coord_next = rsnc_pkg::sat_off(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      coord <= coord_next;
    end
  end

endmodule

/* test/testbench.sv */
// testbench for the ray step to the next unit-cell face
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] start_x = '0;
  logic [31:0] start_y = '0;
  logic [31:0] start_z = '0;
  logic [31:0] heading_x = '0;
  logic [31:0] heading_y = '0;
  logic [31:0] heading_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] next_x;
  logic [31:0] next_y;
  logic [31:0] next_z;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  point_t      face_points_due[$];
  int          fail_count = 0;
  int          sent_count = 0;
  int          seen_count = 0;
  bit          out_idle_on = 1'b1;
  bit          in_idle_on = 1'b1;

  ray_step_to_next_cell_boundary_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .heading_x(heading_x), .heading_y(heading_y), .heading_z(heading_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_x(next_x), .next_y(next_y), .next_z(next_z)
  );

  always #6 clk = ~clk;

  // clamp an offset value to int32 and return two's complement bits
  function automatic logic [31:0] clamp_offset(input longint off);
    if (off < 0) off = 0;
    if (off > 64'sh0_FFFF_FFFF) off = 64'sh0_FFFF_FFFF;
    return off[31:0] ^ 32'h8000_0000;
  endfunction

  // predicted point on the next cell face
  function automatic point_t next_face_point(input logic [31:0] s[3],
                                             input logic [31:0] h[3]);
    logic [31:0] u[3];
    logic [31:0] mag[3];
    bit          neg[3];
    longint      face[3];
    logic [63:0] t[3];
    logic [63:0] tmin;
    logic [63:0] adv;
    longint      gap;
    logic [31:0] r[3];
    point_t      p;
    for (int i = 0; i < 3; i++) begin
      u[i] = s[i] ^ 32'h8000_0000;
      neg[i] = h[i][31];
      mag[i] = neg[i] ? -h[i] : h[i];
      face[i] = longint'({32'h0, u[i] & 32'hFFFF_0000});
      if (h[i] != 0 && !neg[i]) begin
        face[i] += 64'h1_0000;
      end else begin
        if (u[i][15:0] != 0) face[i] += 64'h1_0000;
        face[i] -= 64'h1_0000;
      end
      if (h[i] == 0) begin
        t[i] = '1;
      end else begin
        gap = face[i] - longint'({32'h0, u[i]});
        if (gap < 0) gap = -gap;
        t[i] = (64'(gap) << 32) / {32'h0, mag[i]};
      end
    end
    tmin = t[0];
    if (t[1] < tmin) tmin = t[1];
    if (t[2] < tmin) tmin = t[2];
    for (int i = 0; i < 3; i++) begin
      if (t[i] == tmin) begin
        r[i] = clamp_offset(face[i]);
      end else begin
        adv = {32'h0, mag[i]} * tmin[63:32]
            + (({32'h0, mag[i]} * {32'h0, tmin[31:0]}) >> 32);
        if (adv > 64'h1_FFFF_FFFF) adv = 64'h1_FFFF_FFFF;
        r[i] = clamp_offset(longint'({32'h0, u[i]}) + (neg[i] ? -longint'(adv)
                                                           : longint'(adv)));
      end
    end
    p.x = r[0]; p.y = r[1]; p.z = r[2];
    return p;
  endfunction

  // offer one request after a random gap, if input idling is on, and wait for its acceptance
  task automatic send_ray(input logic [31:0] sx, sy, sz, hx, hy, hz);
    logic [31:0] s[3];
    logic [31:0] h[3];
    int gap_cycles;
    gap_cycles = in_idle_on ? $urandom_range(0, 12) : 0;
    repeat (gap_cycles) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    s[0] = sx; s[1] = sy; s[2] = sz;
    h[0] = hx; h[1] = hy; h[2] = hz;
    start_x <= sx; start_y <= sy; start_z <= sz;
    heading_x <= hx; heading_y <= hy; heading_z <= hz;
    in_valid <= 1'b1;
    // stall is settled by the falling edge and holds until the next rising one
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    face_points_due.push_back(next_face_point(s, h));
    sent_count++;
    // in_valid stays high here; the next call lowers or keeps it
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stall per result when output idling is on, compare in order
  initial begin
    point_t want;
    int stall_cycles;
    @(negedge rst);
    forever begin
      stall_cycles = out_idle_on ? $urandom_range(0, 12) : 0;
      out_stall <= (stall_cycles != 0);
      repeat (stall_cycles) @(posedge clk);
      out_stall <= 1'b0;
      // look at the result before the edge that takes it
      do @(negedge clk); while (!out_valid);
      seen_count++;
      if (face_points_due.size() == 0) begin
        $display("%0t unexpected result %h %h %h", $time, next_x, next_y, next_z);
        fail_count++;
      end else begin
        want = face_points_due.pop_front();
        if (next_x !== want.x) begin
          $display("%0t next_x expected %h actual %h", $time, want.x, next_x);
          fail_count++;
        end
        if (next_y !== want.y) begin
          $display("%0t next_y expected %h actual %h", $time, want.y, next_y);
          fail_count++;
        end
        if (next_z !== want.z) begin
          $display("%0t next_z expected %h actual %h", $time, want.z, next_z);
          fail_count++;
        end
      end
      @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return {16'($urandom_range(0, 7) - 32'd4), 16'h0};
      3: return {16'h0, 16'($urandom)} ^ {{16{$urandom_range(0, 1) == 1}}, 16'h0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_heading();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return ($urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF);
      4: return $signed(32'($urandom_range(0, 32'h3_0000))) - 32'sh1_8000;
      default: return $urandom;
    endcase
  endfunction

  // extremes of every field and the listed special cases
  task automatic test_directed();
    send_ray(0, 0, 0, 32'h1_0000, 32'h2_0000, 32'h3_0000);
    // tie between axes
    send_ray(32'h8000, 32'h8000, 0, 32'h1_0000, 32'h1_0000, 32'h5_0000);
    // all headings zero: every axis snaps down
    send_ray(32'h1_8000, 32'hFFFF_8000, 32'h2_0000, 0, 0, 0);
    // zero heading on a non-minimum axis keeps its coordinate
    send_ray(32'h1234_5678, 32'h8000, 32'h0, 0, 32'h1_0000, 0);
    // faces beyond range
    send_ray(32'h7FFF_FFFF, 32'h7FFF_0000, 0, 32'h1, 32'h1_0000, 0);
    send_ray(32'h8000_0000, 32'h8000_0001, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    // large advance saturating
    send_ray(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 32'h1, 0);
    send_ray(32'h8000_0000, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_ray(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000,
             32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0001);
    send_ray(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0,
             32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_0F0F);
    end_stream();
  endtask

  // random rays with idling on both sides
  task automatic test_random(input int n);
    for (int k = 0; k < n; k++)
      send_ray(pick_coord(), pick_coord(), pick_coord(),
               pick_heading(), pick_heading(), pick_heading());
    end_stream();
  endtask

  // back-to-back requests with no idling, then a pause to drain
  task automatic test_full_rate(input int n);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    for (int k = 0; k < n; k++)
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end_stream();
    while (face_points_due.size() != 0) @(posedge clk);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_full_rate(100);
    test_random(500);
    while (face_points_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d rays incl. directed extremes, ties, zero headings", sent_count);
    $display("checked %0d results under random stalls and full rate", seen_count);
    if (fail_count == 0 && face_points_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
